/* src/assert_macros.svh */
// ------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros used by the checker file
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with reset disable
`define BFSA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bfsa assertion failed");

// same-cycle implication
`define BFSA_IMPLIES(label, clk, rst_n, ante, cons) \
    `BFSA_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`endif

/* src/bfsa_pkg.sv */
// ------------------------------------------------------------------------
// bfsa_pkg
// shared constants and types of the best-fit segment allocator
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfsa_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int ADDR_W       = 32;
    localparam int OWN_W        = 16;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] seg_base;
        logic [ADDR_W-1:0] seg_end;
        logic [OWN_W-1:0]  seg_owner;
    } t_seg;

    localparam int SEG_W = $bits(t_seg);

    typedef struct packed {
        logic [ADDR_W-1:0] hole;
        logic              fits_better;
    } t_hole_res;

endpackage

/* src/bfsa_ram.sv */
// ------------------------------------------------------------------------
// bfsa_ram
// generic simple dual-port ram, one write port, registered read port
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/bfsa_hole_unit.sv */
// ------------------------------------------------------------------------
// bfsa_hole_unit
// shared span subtract and best-fit compare
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfsa_hole_unit import bfsa_pkg::*; (
    input  logic [ADDR_W-1:0] i_lo,
    input  logic [ADDR_W-1:0] i_hi,
    input  logic [ADDR_W-1:0] i_size,
    input  logic [ADDR_W-1:0] i_best,
    input  logic              i_found,
    output t_hole_res         o_res
);

    logic [ADDR_W-1:0] w_hole;

    assign w_hole = (i_hi > i_lo) ? (i_hi - i_lo) : '0;

    always_comb begin
        o_res.hole        = w_hole;
        o_res.fits_better = (w_hole >= i_size) && (!i_found || (w_hole < i_best));
    end

endmodule

/* src/best_fit_segment_allocator_core.sv */
// ------------------------------------------------------------------------
// best_fit_segment_allocator_core
// address-sorted segment table with best-fit allocate and free by owner
// ------------------------------------------------------------------------
// allocate: scan every gap from index 0 to count, shift entries above pos up, place
// free: scan to the first segment of the owner, then shift later entries down
// requests refused in idle skip the scan; one table read and one write per cycle
// result strobe o_done is registered after the last step, receiver cannot stall
// synchronous reset: table empty, total_size and free bytes zero
`timescale 1ns / 1ps

module best_fit_segment_allocator_core import bfsa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_func,
    input  logic [ADDR_W-1:0] i_req_size,
    input  logic [OWN_W-1:0]  i_owner_id,
    output logic              o_done,
    output logic              o_ok,
    output logic [ADDR_W-1:0] o_base_address
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_PLACE,
        S_FSCAN,
        S_SHIFT_DN
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_total, n_total;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_free, n_free;
    logic [ADDR_W-1:0] r_size, n_size;
    logic [OWN_W-1:0]  r_owner, n_owner;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [ADDR_W-1:0] r_prev_end, n_prev_end;
    logic [ADDR_W-1:0] r_best, n_best;
    logic              r_found, n_found;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_done, n_done;
    logic              r_ok, n_ok;
    logic [ADDR_W-1:0] r_base, n_base;

    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    t_seg              w_wdata;
    logic [IDX_W-1:0]  w_raddr;
    t_seg              w_rdata;
    logic [SEG_W-1:0]  w_rdata_raw;

    logic [ADDR_W-1:0] w_lo, w_hi;
    t_hole_res         w_res;

    logic [CNT_W-1:0]  w_idx_inc, w_idx_dec, w_cnt_dec, w_pos_fin;

    assign w_idx_inc = r_idx + 1'b1;
    assign w_idx_dec = r_idx - 1'b1;
    assign w_cnt_dec = r_count - 1'b1;
    assign w_rdata   = t_seg'(w_rdata_raw);
    assign w_pos_fin = w_res.fits_better ? r_idx : r_pos;

    bfsa_ram #(
        .WIDTH (SEG_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (SEG_W'(w_wdata)),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    always_comb begin
        if (r_state == S_FSCAN) begin
            w_lo = w_rdata.seg_base;
            w_hi = w_rdata.seg_end;
        end else begin
            w_lo = (r_idx == '0) ? '0 : r_prev_end;
            w_hi = (r_idx == r_count) ? r_total : w_rdata.seg_base;
        end
    end

    bfsa_hole_unit u_hole (
        .i_lo    (w_lo),
        .i_hi    (w_hi),
        .i_size  (r_size),
        .i_best  (r_best),
        .i_found (r_found),
        .o_res   (w_res)
    );

    always_comb begin
        n_state    = r_state;
        n_total    = r_total;
        n_count    = r_count;
        n_free     = r_free;
        n_size     = r_size;
        n_owner    = r_owner;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_prev_end = r_prev_end;
        n_best     = r_best;
        n_found    = r_found;
        n_addr     = r_addr;
        n_done     = 1'b0;
        n_ok       = r_ok;
        n_base     = r_base;
        w_we       = 1'b0;
        w_waddr    = r_idx[IDX_W-1:0];
        w_wdata    = w_rdata;
        w_raddr    = r_idx[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_size  = i_req_size;
                    n_owner = i_owner_id;
                    n_idx   = '0;
                    w_raddr = '0;
                    if (i_func == FUNC_ALLOC) begin
                        if ((i_req_size == '0) || (r_count >= MAX_CNT) ||
                            (i_req_size > r_free)) begin
                            n_done = 1'b1;
                            n_ok   = 1'b0;
                            n_base = '0;
                        end else begin
                            n_found    = 1'b0;
                            n_prev_end = '0;
                            n_state    = S_SCAN;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_done = 1'b1;
                            n_ok   = 1'b0;
                            n_base = '0;
                        end else begin
                            n_state = S_FSCAN;
                        end
                    end
                end else if (i_cfg_valid) begin
                    n_total = i_cfg_data;
                    n_count = '0;
                    n_free  = i_cfg_data;
                end
            end
            S_SCAN: begin
                n_prev_end = w_rdata.seg_end;
                if (w_res.fits_better) begin
                    n_found = 1'b1;
                    n_best  = w_res.hole;
                    n_pos   = r_idx;
                    n_addr  = w_lo;
                end
                if (r_idx == r_count) begin
                    if (!(w_res.fits_better || r_found)) begin
                        n_done  = 1'b1;
                        n_ok    = 1'b0;
                        n_base  = '0;
                        n_state = S_IDLE;
                    end else if (w_pos_fin == r_count) begin
                        n_state = S_PLACE;
                    end else begin
                        n_idx   = w_cnt_dec;
                        w_raddr = w_cnt_dec[IDX_W-1:0];
                        n_state = S_SHIFT_UP;
                    end
                end else begin
                    n_idx   = w_idx_inc;
                    w_raddr = w_idx_inc[IDX_W-1:0];
                end
            end
            S_SHIFT_UP: begin
                w_we    = 1'b1;
                w_waddr = w_idx_inc[IDX_W-1:0];
                w_wdata = w_rdata;
                if (r_idx == r_pos) begin
                    n_state = S_PLACE;
                end else begin
                    n_idx   = w_idx_dec;
                    w_raddr = w_idx_dec[IDX_W-1:0];
                end
            end
            S_PLACE: begin
                w_we              = 1'b1;
                w_waddr           = r_pos[IDX_W-1:0];
                w_wdata.seg_base  = r_addr;
                w_wdata.seg_end   = r_addr + r_size;
                w_wdata.seg_owner = r_owner;
                n_count           = r_count + 1'b1;
                n_free            = r_free - r_size;
                n_done            = 1'b1;
                n_ok              = 1'b1;
                n_base            = r_addr;
                n_state           = S_IDLE;
            end
            S_FSCAN: begin
                if (w_rdata.seg_owner == r_owner) begin
                    n_free = r_free + w_res.hole;
                    if (w_idx_inc == r_count) begin
                        n_count = w_cnt_dec;
                        n_done  = 1'b1;
                        n_ok    = 1'b1;
                        n_base  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = w_idx_inc;
                        w_raddr = w_idx_inc[IDX_W-1:0];
                        n_state = S_SHIFT_DN;
                    end
                end else if (w_idx_inc == r_count) begin
                    n_done  = 1'b1;
                    n_ok    = 1'b0;
                    n_base  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx   = w_idx_inc;
                    w_raddr = w_idx_inc[IDX_W-1:0];
                end
            end
            S_SHIFT_DN: begin
                w_we    = 1'b1;
                w_waddr = w_idx_dec[IDX_W-1:0];
                w_wdata = w_rdata;
                if (w_idx_inc == r_count) begin
                    n_count = w_cnt_dec;
                    n_done  = 1'b1;
                    n_ok    = 1'b1;
                    n_base  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx   = w_idx_inc;
                    w_raddr = w_idx_inc[IDX_W-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_count <= '0;
            r_free  <= '0;
            r_found <= 1'b0;
            r_done  <= 1'b0;
            r_ok    <= 1'b0;
            r_base  <= '0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_count <= n_count;
            r_free  <= n_free;
            r_found <= n_found;
            r_done  <= n_done;
            r_ok    <= n_ok;
            r_base  <= n_base;
        end
        r_size     <= n_size;
        r_owner    <= n_owner;
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_prev_end <= n_prev_end;
        r_best     <= n_best;
        r_addr     <= n_addr;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_cfg_ready    = (r_state == S_IDLE) && !i_start;
    assign o_done         = r_done;
    assign o_ok           = r_ok;
    assign o_base_address = r_base;

endmodule

/* src/bfsa_checker.sv */
// ------------------------------------------------------------------------
// bfsa_checker
// port-level assertions for the best-fit segment allocator core
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bfsa_checker import bfsa_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              o_done,
    input logic              o_ok,
    input logic [ADDR_W-1:0] o_base_address
);

    // failed transaction reports a zero base
    `BFSA_IMPLIES(a_fail_base_zero, i_clk, i_rst_n, o_done && !o_ok, o_base_address == '0)

    // accepted transaction either runs or finishes at once
    `BFSA_ASSERT(a_start_progress, i_clk, i_rst_n, (i_start && !o_busy) |=> (o_busy || o_done))

    // leaving busy always delivers a result
    `BFSA_IMPLIES(a_busy_end_done, i_clk, i_rst_n, $fell(o_busy) && $past(i_rst_n), o_done)

    // result only when the core is idle again
    `BFSA_IMPLIES(a_done_idle, i_clk, i_rst_n, o_done, !o_busy)

endmodule

bind best_fit_segment_allocator_core bfsa_checker u_bfsa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_done         (o_done),
    .o_ok           (o_ok),
    .o_base_address (o_base_address)
);

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb - best-fit segment allocator testbench
// ----------------------------------------------------------------------------
// Drives allocate and free requests through the start/busy command port.
// Size settings are written through the config channel between phases.
// A scoreboard keeps its own address-sorted segment table and predicts the
// ok flag and base address of every request. Each strobed result is compared
// field by field against the oldest prediction. The run has a short directed
// part covering zero size, fragmented memory, ties, unknown
// owners and re-init. It then runs random phases at several memory sizes
// with bursty traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import bfsa_pkg::*; ();

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int END_WAIT    = 150;
    localparam int PRINT_CAP   = 40;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] base;
    } t_alloc_result;

    class alloc_scoreboard;
        logic [ADDR_W-1:0] total_size;
        logic [ADDR_W-1:0] free_bytes;
        logic [ADDR_W-1:0] seg_lo [MAX_SEGMENTS];
        logic [ADDR_W-1:0] seg_hi [MAX_SEGMENTS];
        logic [OWN_W-1:0]  seg_own [MAX_SEGMENTS];
        int                seg_count;
        t_alloc_result     expected_q [$];
        int                error_count;
        int                n_requests;
        int                n_placed;
        int                n_freed;
        int                n_rejected;
        int                n_full;
        int                n_cfg;
        int                max_count;

        function new();
            total_size  = '0;
            free_bytes  = '0;
            seg_count   = 0;
            error_count = 0;
            n_requests  = 0;
            n_placed    = 0;
            n_freed     = 0;
            n_rejected  = 0;
            n_full      = 0;
            n_cfg       = 0;
            max_count   = 0;
        endfunction

        task report(string msg);
            if (error_count < PRINT_CAP) begin
                $display("tb: mismatch at %0t: %s", $realtime, msg);
            end
            error_count++;
        endtask

        function int pending();
            return expected_q.size();
        endfunction

        // writing the size empties the table
        function void reinit(logic [ADDR_W-1:0] size);
            total_size = size;
            free_bytes = size;
            seg_count  = 0;
            n_cfg++;
        endfunction

        function t_alloc_result place(logic [ADDR_W-1:0] size, logic [OWN_W-1:0] owner);
            t_alloc_result   res;
            logic [ADDR_W:0] lo;
            logic [ADDR_W:0] hi;
            logic [ADDR_W:0] hole;
            logic [ADDR_W:0] best;
            logic [ADDR_W-1:0] addr;
            int              pos;
            bit              found;
            res   = '0;
            best  = '0;
            addr  = '0;
            pos   = 0;
            found = 1'b0;
            if (seg_count >= MAX_SEGMENTS) begin
                n_full++;
            end
            if (size == '0 || seg_count >= MAX_SEGMENTS || size > free_bytes) begin
                return res;
            end
            // smallest hole that fits, lowest address on ties
            for (int i = 0; i <= seg_count; i++) begin
                lo   = (i == 0) ? '0 : {1'b0, seg_hi[i-1]};
                hi   = (i == seg_count) ? {1'b0, total_size} : {1'b0, seg_lo[i]};
                hole = (hi > lo) ? hi - lo : '0;
                if (hole >= {1'b0, size} && (!found || hole < best)) begin
                    found = 1'b1;
                    best  = hole;
                    pos   = i;
                    addr  = lo[ADDR_W-1:0];
                end
            end
            if (!found) begin
                return res;
            end
            for (int i = seg_count; i > pos; i--) begin
                seg_lo[i]  = seg_lo[i-1];
                seg_hi[i]  = seg_hi[i-1];
                seg_own[i] = seg_own[i-1];
            end
            seg_lo[pos]  = addr;
            seg_hi[pos]  = addr + size;
            seg_own[pos] = owner;
            seg_count++;
            free_bytes -= size;
            res.ok   = 1'b1;
            res.base = addr;
            return res;
        endfunction

        function t_alloc_result release_owner(logic [OWN_W-1:0] owner);
            t_alloc_result res;
            res = '0;
            for (int i = 0; i < seg_count; i++) begin
                if (seg_own[i] == owner) begin
                    free_bytes += (seg_hi[i] >= seg_lo[i]) ? seg_hi[i] - seg_lo[i] : '0;
                    for (int j = i; j + 1 < seg_count; j++) begin
                        seg_lo[j]  = seg_lo[j+1];
                        seg_hi[j]  = seg_hi[j+1];
                        seg_own[j] = seg_own[j+1];
                    end
                    seg_count--;
                    res.ok = 1'b1;
                    return res;
                end
            end
            return res;
        endfunction

        function void note_request(logic func, logic [ADDR_W-1:0] size,
                                   logic [OWN_W-1:0] owner);
            t_alloc_result res;
            res = (func == FUNC_ALLOC) ? place(size, owner) : release_owner(owner);
            n_requests++;
            if (!res.ok) begin
                n_rejected++;
            end else if (func == FUNC_ALLOC) begin
                n_placed++;
            end else begin
                n_freed++;
            end
            if (seg_count > max_count) begin
                max_count = seg_count;
            end
            expected_q.insert(expected_q.size(), res);
        endfunction

        task check_result(logic ok, logic [ADDR_W-1:0] base);
            t_alloc_result exp_res;
            if (expected_q.size() == 0) begin
                report($sformatf("result ok=%0b base=%08h with nothing outstanding", ok, base));
                return;
            end
            exp_res = expected_q.pop_front();
            if (ok !== exp_res.ok) begin
                report($sformatf("ok %0b, expected %0b", ok, exp_res.ok));
            end
            if (base !== exp_res.base) begin
                report($sformatf("base_address %08h, expected %08h", base, exp_res.base));
            end
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [ADDR_W-1:0] i_cfg_data;
    logic              i_start;
    logic              o_busy;
    logic              i_func;
    logic [ADDR_W-1:0] i_req_size;
    logic [OWN_W-1:0]  i_owner_id;
    logic              o_done;
    logic              o_ok;
    logic [ADDR_W-1:0] o_base_address;

    alloc_scoreboard sb;
    int              cycle_count;

    best_fit_segment_allocator_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_func         (i_func),
        .i_req_size     (i_req_size),
        .i_owner_id     (i_owner_id),
        .o_done         (o_done),
        .o_ok           (o_ok),
        .o_base_address (o_base_address)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result first: a transaction accepted on this edge cannot be answered on it
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                sb.check_result(o_ok, o_base_address);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.reinit(i_cfg_data);
            end
            if (i_start && !o_busy) begin
                sb.note_request(i_func, i_req_size, i_owner_id);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: timeout after %0d cycles", cycle_count);
        $display("tb: FAIL");
        $finish;
    end

    task automatic send_request(input logic func, input logic [ADDR_W-1:0] size,
                                input logic [OWN_W-1:0] owner);
        i_start    <= 1'b1;
        i_func     <= func;
        i_req_size <= size;
        i_owner_id <= owner;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            i_start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_total(input logic [ADDR_W-1:0] size);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] pick_size(input logic [ADDR_W-1:0] total);
        logic [ADDR_W-1:0] span;
        span = ((total >> 5) == '0) ? ADDR_W'(1) : total >> 5;
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return $urandom;
            2:       return total;
            3:       return $urandom_range(1, (total == '0) ? 1 : total);
            default: return $urandom_range(1, span);
        endcase
    endfunction

    function automatic logic [OWN_W-1:0] pick_owner();
        case ($urandom_range(0, 9))
            0:       return OWN_W'($urandom);
            1:       return '1;
            default: return OWN_W'($urandom_range(0, 7));
        endcase
    endfunction

    task automatic run_phase(input int n_items, input int alloc_pct, input bit no_gaps);
        int                burst;
        int                sent;
        logic              func;
        logic [ADDR_W-1:0] size;
        logic [OWN_W-1:0]  owner;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < n_items; k++) begin
                func  = ($urandom_range(0, 99) < alloc_pct) ? FUNC_ALLOC : FUNC_FREE;
                size  = pick_size(sb.total_size);
                owner = pick_owner();
                send_request(func, size, owner);
                sent++;
            end
            if (!no_gaps) begin
                pause($urandom_range(0, 12));
            end
            if ($urandom_range(0, 19) == 0) begin
                drain();
            end
        end
    endtask

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_start     = 1'b0;
        i_func      = FUNC_ALLOC;
        i_req_size  = '0;
        i_owner_id  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty memory out of reset
        send_request(FUNC_ALLOC, 32'd1, 16'd0);
        send_request(FUNC_FREE, 32'd0, 16'd0);

        // fragmentation, best fit and ties
        write_total(32'd1000);
        send_request(FUNC_ALLOC, 32'd0, 16'd1);
        send_request(FUNC_ALLOC, 32'd100, 16'd1);
        send_request(FUNC_ALLOC, 32'd200, 16'd2);
        send_request(FUNC_ALLOC, 32'd100, 16'd3);
        send_request(FUNC_ALLOC, 32'd600, 16'hFFFF);
        send_request(FUNC_ALLOC, 32'd1, 16'd4);
        send_request(FUNC_FREE, 32'd0, 16'd2);
        send_request(FUNC_ALLOC, 32'd150, 16'd5);
        send_request(FUNC_FREE, 32'd0, 16'd1);
        send_request(FUNC_ALLOC, 32'd120, 16'd6);
        send_request(FUNC_ALLOC, 32'd50, 16'd7);
        send_request(FUNC_FREE, 32'd0, 16'd3);
        send_request(FUNC_ALLOC, 32'd100, 16'd8);
        send_request(FUNC_FREE, 32'd0, 16'd1234);
        send_request(FUNC_FREE, 32'd0, 16'hFFFF);

        // full address range
        write_total(32'hFFFF_FFFF);
        send_request(FUNC_ALLOC, 32'hFFFF_FFFF, 16'hAAAA);
        send_request(FUNC_ALLOC, 32'd1, 16'h5555);
        send_request(FUNC_FREE, 32'd0, 16'hAAAA);
        send_request(FUNC_ALLOC, 32'h5555_5555, 16'h5555);
        send_request(FUNC_FREE, 32'hFFFF_FFFF, 16'h5555);
        send_request(FUNC_ALLOC, 32'd10, 16'd9);
        send_request(FUNC_ALLOC, 32'd10, 16'd9);
        send_request(FUNC_FREE, 32'd0, 16'd9);

        write_total(32'hFFFF_FFFF);
        run_phase(250, 70, 1'b0);
        write_total(32'd4096);
        run_phase(250, 65, 1'b1);
        write_total($urandom);
        run_phase(250, 65, 1'b0);
        write_total(32'd64);
        run_phase(200, 60, 1'b0);
        write_total(32'd0);
        run_phase(50, 70, 1'b1);
        write_total($urandom_range(32'h0001_0000, 32'h0100_0000));
        run_phase(250, 75, 1'b0);
        write_total(32'hFFFF_FFFF);
        run_phase(150, 95, 1'b1);

        drain();
        repeat (END_WAIT) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        end

        $display("tb: %0d requests over %0d size settings: %0d placed, %0d freed, %0d refused",
                 sb.n_requests, sb.n_cfg, sb.n_placed, sb.n_freed, sb.n_rejected);
        $display("tb: table peaked at %0d segments, %0d allocations hit a full table, %0d errors",
                 sb.max_count, sb.n_full, sb.error_count);
        if (sb.error_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/bfsa_pkg.sv
src/bfsa_ram.sv
src/bfsa_hole_unit.sv
src/best_fit_segment_allocator_core.sv
src/bfsa_checker.sv
verif/tb.sv
